FILE: sv/set_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the symmetric edge table.
// No dependencies; set_emem and symmetric_edge_table import it.
package set_pkg;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_UPSERT   = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_FIND_ST  = 3'd3,
    CMD_FIND_CAT = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_APPEND,
    ST_UPD,
    ST_UPD_WR,
    ST_LAST_RD,
    ST_LAST_WT,
    ST_NEXT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]      other;
    logic [7:0]      category;
    logic [7:0]      status;
    logic [2:0][7:0] wt;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);
  localparam logic [1:0] LAST_WEIGHT = 2'd2;

endpackage

FILE: sv/set_sat.sv
`timescale 1ns / 1ps
// Saturating weight update: base plus signed delta, clamped to 0..255.
// Depends on nothing; shared by the sequencer for all three weights.
module set_sat (
  input  logic              [7:0] base,
  input  logic signed       [7:0] delta,
  output logic              [7:0] result
);

  logic signed [9:0] sum;

  assign sum = $signed({2'b00, base}) + 10'(delta);

  always_comb begin
    if (sum < 0) begin
      result = 8'd0;
    end else if (sum > 10'sd255) begin
      result = 8'd255;
    end else begin
      result = sum[7:0];
    end
  end

endmodule

FILE: sv/set_cmem.sv
`timescale 1ns / 1ps
// Per-node slot count memory with one valid bit per node, cleared at reset.
// Depends on nothing; read data is registered.
module set_cmem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    q_r;
  logic             qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r  <= mem[raddr];
    qv_r <= valid_r[raddr];
  end

  // A node never written reads as an empty list.
  assign rdata = qv_r ? q_r : '0;

endmodule

FILE: sv/set_emem.sv
`timescale 1ns / 1ps
// Edge slot memory: one write port, one registered read port.
// Depends on set_pkg for the edge record type.
module set_emem
  import set_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output edge_t         rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  edge_t         wdata
);

  edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/symmetric_edge_table.sv
`timescale 1ns / 1ps
// Top level of the symmetric edge table: command sequencer and datapath.
// Depends on set_pkg, set_cmem, set_emem and set_sat.
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_ready  | command, nodes, keys, weights, deltas
//   out_     | output    | out_valid / out_ready| ok, found, other_node
//   cfg_     | input     | cfg_wr_en            | keep status code
//
// Each side of a command reads its list one slot at a time through the single edge
// memory read port. Reset clears the state machine, the result valid flag and all
// slot counts at once. The input is refused while a command is at work; a stalled
// result holds its register.
module symmetric_edge_table
  import set_pkg::*;
#(
  parameter int NODE_COUNT     = 256,
  parameter int SLOTS_PER_NODE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic        [7:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic        [2:0] in_cmd,
  input  logic        [7:0] in_node_a,
  input  logic        [7:0] in_node_b,
  input  logic        [7:0] in_category,
  input  logic        [7:0] in_status,
  input  logic        [7:0] in_weight_one,
  input  logic        [7:0] in_weight_two,
  input  logic        [7:0] in_weight_three,
  input  logic signed [7:0] in_delta_one,
  input  logic signed [7:0] in_delta_two,
  input  logic signed [7:0] in_delta_three,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic              out_found,
  output logic        [7:0] out_other_node
);

  localparam int IW    = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
  localparam int SW    = $clog2(SLOTS_PER_NODE + 1);
  localparam int EN    = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int NW    = $clog2(EN);
  localparam int EAW   = NW + IW;
  localparam int EDEPTH = EN * (2 ** IW);

  state_t state_r, state_nxt;

  logic [7:0]      keep_r;
  cmd_t            cmd_r;
  logic [7:0]      a_r, b_r, cat_r, st_r;
  logic [2:0][7:0] w_r;
  logic [2:0][7:0] d_r;
  logic            side_r;
  logic [SW-1:0]   cnt_r, i_r;
  logic [IW-1:0]   k_r;
  logic            nv_r, hit_r, oa_r;
  logic            ok_r, found_r;
  logic [7:0]      other_r;
  logic [1:0]      wsel_r;
  edge_t           edge_r;

  logic [7:0]      node, oth;
  logic [NW-1:0]   nidx;
  logic            nv, can_app, is_find, key_eq;
  logic [SW-1:0]   cnt_q, cnt_p1, cnt_m1;
  edge_t           eq;
  logic [7:0]      sat_out;

  logic            cm_we, em_we;
  logic [SW-1:0]   cm_wdata;
  logic [IW-1:0]   em_rslot, em_wslot;
  edge_t           em_wdata;

  assign node    = side_r ? b_r : a_r;
  assign oth     = side_r ? a_r : b_r;
  assign nidx    = NW'(node);
  assign nv      = 32'(node) < NODE_COUNT;
  assign can_app = nv_r && (32'(cnt_r) < SLOTS_PER_NODE);
  assign cnt_p1  = cnt_r + SW'(1);
  assign cnt_m1  = cnt_r - SW'(1);
  assign is_find = (cmd_r == CMD_FIND_ST) || (cmd_r == CMD_FIND_CAT);

  always_comb begin
    if (cmd_r == CMD_FIND_ST) begin
      key_eq = eq.status == st_r;
    end else if (cmd_r == CMD_FIND_CAT) begin
      key_eq = eq.category == cat_r;
    end else begin
      key_eq = eq.other == oth;
    end
  end

  set_cmem #(.DEPTH(EN), .AW(NW), .DW(SW)) u_cmem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (nidx),
    .rdata (cnt_q),
    .we    (cm_we),
    .waddr (nidx),
    .wdata (cm_wdata)
  );

  set_emem #(.DEPTH(EDEPTH), .AW(EAW)) u_emem (
    .clk   (clk),
    .raddr ({nidx, em_rslot}),
    .rdata (eq),
    .we    (em_we),
    .waddr ({nidx, em_wslot}),
    .wdata (em_wdata)
  );

  set_sat u_sat (
    .base   (edge_r.wt[wsel_r]),
    .delta  ($signed(d_r[wsel_r])),
    .result (sat_out)
  );

  assign in_ready = (state_r == ST_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd > 3'(CMD_FIND_CAT)) ? ST_FIN : ST_CNT_RD;
        end
      end
      ST_CNT_RD:   state_nxt = ST_CNT_WT;
      ST_CNT_WT: begin
        state_nxt = (cmd_r == CMD_ADD && side_r) ? ST_APPEND : ST_SCAN_RD;
      end
      ST_SCAN_RD:  state_nxt = (i_r < cnt_r) ? ST_SCAN_CMP : ST_DECIDE;
      ST_SCAN_CMP: state_nxt = key_eq ? ST_DECIDE : ST_SCAN_RD;
      ST_DECIDE: begin
        case (cmd_r)
          CMD_ADD:    state_nxt = hit_r ? ST_FIN : ST_APPEND;
          CMD_UPSERT: state_nxt = (hit_r || can_app) ? ST_UPD : ST_NEXT;
          CMD_REMOVE: state_nxt = hit_r ? ST_LAST_RD : ST_NEXT;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_APPEND:   state_nxt = ST_NEXT;
      ST_UPD:      state_nxt = (wsel_r == LAST_WEIGHT) ? ST_UPD_WR : ST_UPD;
      ST_UPD_WR:   state_nxt = ST_NEXT;
      ST_LAST_RD:  state_nxt = ST_LAST_WT;
      ST_LAST_WT:  state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = side_r ? ST_FIN : ST_CNT_RD;
      ST_FIN:      state_nxt = (!out_valid || out_ready) ? ST_IDLE : ST_FIN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    cm_we    = 1'b0;
    cm_wdata = cnt_p1;
    em_we    = 1'b0;
    em_rslot = i_r[IW-1:0];
    em_wslot = k_r;
    em_wdata = edge_r;
    case (state_r)
      ST_DECIDE: begin
        // An upsert of a missing side claims the next slot now.
        cm_we = (cmd_r == CMD_UPSERT) && !hit_r && can_app;
      end
      ST_APPEND: begin
        cm_we    = can_app;
        em_we    = can_app;
        em_wslot = cnt_r[IW-1:0];
        em_wdata = '{other: oth, category: cat_r, status: st_r, wt: w_r};
      end
      ST_UPD_WR: begin
        em_we = 1'b1;
      end
      ST_LAST_RD: begin
        em_rslot = cnt_m1[IW-1:0];
      end
      ST_LAST_WT: begin
        // Swap delete: the last entry moves into the freed slot.
        cm_we    = 1'b1;
        cm_wdata = cnt_m1;
        em_we    = 1'b1;
        em_wdata = eq;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      keep_r    <= 8'd255;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
      if (state_r == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r   <= cmd_t'(in_cmd);
        a_r     <= in_node_a;
        b_r     <= in_node_b;
        cat_r   <= in_category;
        st_r    <= in_status;
        w_r     <= {in_weight_three, in_weight_two, in_weight_one};
        d_r     <= {in_delta_three, in_delta_two, in_delta_one};
        side_r  <= 1'b0;
        ok_r    <= 1'b1;
        found_r <= 1'b0;
        other_r <= 8'd0;
      end
      ST_CNT_WT: begin
        cnt_r <= nv ? cnt_q : '0;
        nv_r  <= nv;
        i_r   <= '0;
        hit_r <= 1'b0;
      end
      ST_SCAN_CMP: begin
        if (key_eq) begin
          hit_r  <= 1'b1;
          k_r    <= i_r[IW-1:0];
          edge_r <= eq;
        end else begin
          i_r <= i_r + SW'(1);
        end
      end
      ST_DECIDE: begin
        wsel_r <= 2'd0;
        if (is_find && hit_r) begin
          found_r <= 1'b1;
          other_r <= edge_r.other;
        end
        if (cmd_r == CMD_ADD && hit_r) begin
          ok_r <= 1'b0;
        end
        if (cmd_r == CMD_UPSERT && !hit_r) begin
          edge_r <= '{other: oth, category: 8'd0, status: 8'd0, wt: '0};
          k_r    <= cnt_r[IW-1:0];
        end
      end
      ST_APPEND: begin
        if (!side_r) begin
          oa_r <= can_app;
        end else begin
          ok_r <= oa_r && can_app;
        end
      end
      ST_UPD: begin
        edge_r.wt[wsel_r] <= sat_out;
        wsel_r            <= wsel_r + 2'd1;
        if (wsel_r == 2'd0 && st_r != keep_r) begin
          edge_r.status <= st_r;
        end
      end
      ST_NEXT: begin
        side_r <= 1'b1;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_ok         <= ok_r;
          out_found      <= found_r;
          out_other_node <= other_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_RD) |-> (32'(cnt_r) <= SLOTS_PER_NODE))
    else $error("slot count above list capacity");

  a_move_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST_WT) |-> (hit_r && (SW'(k_r) < cnt_r)))
    else $error("swap delete without a live match");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_ok)
    else $error("find result reported with ok low");

  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CMP) |-> ($past(state_r) == ST_SCAN_RD))
    else $error("slot compare without a preceding read");
`endif

endmodule

FILE: tb/sv/edge_table_checker.sv
`timescale 1ns / 1ps
// Checker for the symmetric edge table: watches both channels, predicts results.
// Depends on set_pkg; instantiated by tb_symmetric_edge_table beside the block.
module edge_table_checker
  import set_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic        [7:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic        [2:0] in_cmd,
  input  logic        [7:0] in_node_a,
  input  logic        [7:0] in_node_b,
  input  logic        [7:0] in_category,
  input  logic        [7:0] in_status,
  input  logic        [7:0] in_weight_one,
  input  logic        [7:0] in_weight_two,
  input  logic        [7:0] in_weight_three,
  input  logic signed [7:0] in_delta_one,
  input  logic signed [7:0] in_delta_two,
  input  logic signed [7:0] in_delta_three,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_ok,
  input  logic              out_found,
  input  logic        [7:0] out_other_node,
  output int                fail_count,
  output int                pending_count
);

  localparam int SLOTS = 16;

  typedef struct packed {
    logic       ok;
    logic       found;
    logic [7:0] other_node;
  } reply_t;

  typedef struct {
    logic [7:0] nbr;
    logic [7:0] cat;
    logic [7:0] st;
    logic [7:0] w [3];
  } link_t;

  link_t      links [256][SLOTS];
  int         link_count [256];
  logic [7:0] keep_code;
  reply_t     expected_replies [$];

  assign pending_count = expected_replies.size();

  function automatic int find_link(int node, logic [7:0] nbr);
    for (int i = 0; i < link_count[node]; i++)
      if (links[node][i].nbr == nbr) return i;
    return -1;
  endfunction

  function automatic int add_link(int node, logic [7:0] nbr, logic [7:0] cat,
                                  logic [7:0] st, logic [7:0] w1, logic [7:0] w2,
                                  logic [7:0] w3);
    int k;
    if (link_count[node] >= SLOTS) return -1;
    k = link_count[node];
    links[node][k].nbr = nbr;
    links[node][k].cat = cat;
    links[node][k].st = st;
    links[node][k].w[0] = w1;
    links[node][k].w[1] = w2;
    links[node][k].w[2] = w3;
    link_count[node]++;
    return k;
  endfunction

  function automatic logic [7:0] clamp_add(logic [7:0] base, logic signed [7:0] d);
    int v;
    v = int'(base) + int'(d);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic void merge_side(int node, logic [7:0] nbr, logic [7:0] st,
                                     logic signed [7:0] d [3]);
    int k;
    k = find_link(node, nbr);
    if (k < 0) k = add_link(node, nbr, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    if (k < 0) return;
    if (st != keep_code) links[node][k].st = st;
    for (int j = 0; j < 3; j++) links[node][k].w[j] = clamp_add(links[node][k].w[j], d[j]);
  endfunction

  function automatic void drop_side(int node, logic [7:0] nbr);
    int k;
    k = find_link(node, nbr);
    if (k < 0) return;
    links[node][k] = links[node][link_count[node] - 1];
    link_count[node]--;
  endfunction

  function automatic reply_t apply_command();
    reply_t r;
    logic signed [7:0] d [3];
    int a;
    int b;
    bit oa;
    bit ob;
    r = '{ok: 1'b1, found: 1'b0, other_node: 8'd0};
    a = in_node_a;
    b = in_node_b;
    d[0] = in_delta_one;
    d[1] = in_delta_two;
    d[2] = in_delta_three;
    case (in_cmd)
      CMD_ADD: begin
        if (find_link(a, in_node_b) >= 0) begin
          r.ok = 1'b0;
        end else begin
          oa = add_link(a, in_node_b, in_category, in_status, in_weight_one,
                        in_weight_two, in_weight_three) >= 0;
          ob = add_link(b, in_node_a, in_category, in_status, in_weight_one,
                        in_weight_two, in_weight_three) >= 0;
          r.ok = oa && ob;
        end
      end
      CMD_UPSERT: begin
        merge_side(a, in_node_b, in_status, d);
        merge_side(b, in_node_a, in_status, d);
      end
      CMD_REMOVE: begin
        drop_side(a, in_node_b);
        drop_side(b, in_node_a);
      end
      CMD_FIND_ST, CMD_FIND_CAT: begin
        for (int i = 0; i < link_count[a]; i++) begin
          if ((in_cmd == CMD_FIND_ST) ? links[a][i].st == in_status
                                      : links[a][i].cat == in_category) begin
            r.found = 1'b1;
            r.other_node = links[a][i].nbr;
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst_n) begin
      keep_code <= 8'd255;
      for (int n = 0; n < 256; n++) link_count[n] = 0;
      expected_replies.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) keep_code <= cfg_wr_data;
      if (in_valid && in_ready) expected_replies.push_back(apply_command());
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with none expected at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_replies.pop_front();
          if (exp_r.ok !== out_ok || exp_r.found !== out_found ||
              exp_r.other_node !== out_other_node) begin
            if (fail_count < 10)
              $display("ERROR: expected ok=%0d found=%0d other=%0d, got %0d %0d %0d",
                       exp_r.ok, exp_r.found, exp_r.other_node,
                       out_ok, out_found, out_other_node);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_symmetric_edge_table.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the symmetric edge table.
// Depends on set_pkg, symmetric_edge_table and edge_table_checker.
module tb_symmetric_edge_table;
  import set_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic        [7:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic        [2:0] in_cmd;
  logic        [7:0] in_node_a;
  logic        [7:0] in_node_b;
  logic        [7:0] in_category;
  logic        [7:0] in_status;
  logic        [7:0] in_weight_one;
  logic        [7:0] in_weight_two;
  logic        [7:0] in_weight_three;
  logic signed [7:0] in_delta_one;
  logic signed [7:0] in_delta_two;
  logic signed [7:0] in_delta_three;
  logic              out_valid;
  logic              out_ready;
  logic              out_ok;
  logic              out_found;
  logic        [7:0] out_other_node;
  int                fail_count;
  int                pending_count;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_off;
  longint            cycle_count;

  symmetric_edge_table #(.NODE_COUNT(256), .SLOTS_PER_NODE(16)) DUT (.*);

  edge_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run ends here if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("tb_symmetric_edge_table NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high after a transfer until the next item or an idle cycle replaces it,
  // so back-to-back items see a single assignment per edge.
  task automatic send_item(logic [2:0] c, logic [7:0] a, logic [7:0] b,
                           logic [7:0] cat, logic [7:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_node_a <= a;
    in_node_b <= b;
    in_category <= cat;
    in_status <= st;
    in_weight_one <= 8'($urandom);
    in_weight_two <= 8'($urandom);
    in_weight_three <= 8'($urandom);
    in_delta_one <= 8'($urandom);
    in_delta_two <= 8'($urandom);
    in_delta_three <= 8'($urandom);
    // Ready is checked mid-cycle, where it is stable, and the transfer is the next edge.
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_keep(logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly a small node pool so lists fill, overflow and collide.
  task automatic random_item();
    logic [7:0] a;
    logic [7:0] b;
    int pool;
    pool = $urandom_range(3) == 0 ? 255 : 7;
    a = 8'($urandom_range(pool));
    b = ($urandom_range(9) == 0) ? a : 8'($urandom_range(pool));
    send_item(3'($urandom_range(7) == 7 ? $urandom_range(7) : $urandom_range(4)), a, b,
              $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3)),
              $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3)));
  endtask

  initial begin
    cycle_count = 0;
    hold_off = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD;
    {in_node_a, in_node_b, in_category, in_status} = '0;
    {in_weight_one, in_weight_two, in_weight_three} = '0;
    {in_delta_one, in_delta_two, in_delta_three} = '0;
    send_idle_pct = 30;
    recv_idle_pct = 70;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every command, self loops, full lists, unused codes.
    send_item(CMD_FIND_ST, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_ADD, 8'd0, 8'd255, 8'd255, 8'd0);
    send_item(CMD_ADD, 8'd0, 8'd255, 8'd1, 8'd1);
    send_item(CMD_ADD, 8'd9, 8'd9, 8'd4, 8'd5);
    send_item(CMD_UPSERT, 8'd9, 8'd9, 8'd0, 8'd255);
    send_item(CMD_UPSERT, 8'd20, 8'd21, 8'd0, 8'd7);
    send_item(CMD_FIND_CAT, 8'd255, 8'd0, 8'd255, 8'd0);
    send_item(CMD_FIND_ST, 8'd20, 8'd0, 8'd0, 8'd7);
    for (int i = 1; i <= 17; i++) send_item(CMD_ADD, 8'd3, 8'(i + 30), 8'(i), 8'(i));
    send_item(CMD_UPSERT, 8'd3, 8'd100, 8'd0, 8'd1);
    send_item(CMD_REMOVE, 8'd9, 8'd9, 8'd0, 8'd0);
    send_item(CMD_REMOVE, 8'd3, 8'd31, 8'd0, 8'd0);
    send_item(3'd5, 8'd1, 8'd2, 8'd0, 8'd0);
    send_item(3'd7, 8'd1, 8'd2, 8'd0, 8'd0);

    write_keep(8'd0);
    for (int i = 0; i < 650; i++) random_item();
    send_idle_pct = 70;
    recv_idle_pct = 30;
    write_keep(8'd2);
    // Long receiver stall while the sender keeps offering.
    hold_off = 400;
    for (int i = 0; i < 650; i++) random_item();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_keep(8'd255);
    for (int i = 0; i < 650; i++) random_item();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_symmetric_edge_table OK");
    end else begin
      $display("tb_symmetric_edge_table NOT OK");
    end
    $finish;
  end

endmodule
